### sv/esps_pkg.sv
// Package for the streaming edge partition scorer: shared widths, constants,
// register indexes, the sequencer state type and the divider status struct.
// No dependencies.
`default_nettype none

package esps_pkg;

  localparam int unsigned DEG_W  = 32;
  localparam int unsigned LOAD_W = 32;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned DIV_W  = 64;
  localparam int unsigned BAL_W  = 48;
  localparam int unsigned REP_W  = 19;
  localparam int unsigned SCORE_W = 57;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;
  localparam logic [63:0] BAL_MAX = 64'h0000_FFFF_FFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_PARTS_IN_USE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_WEIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_EPSILON = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODU,
    ST_MODU_W,
    ST_MODV,
    ST_MODV_W,
    ST_RDU,
    ST_UPDU,
    ST_RDV,
    ST_UPDV,
    ST_DIVU,
    ST_DIVU_W,
    ST_DIVV,
    ST_DIVV_W,
    ST_PCHK,
    ST_PDIV_W,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_CMP,
    ST_LOAD,
    ST_WRU,
    ST_WRV,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### sv/esps_ifs.sv
// Handshake channels of the edge partition scorer: the edge input channel and
// the partition result channel. Depends on esps_pkg.
`default_nettype none

interface esps_edge_if;
  logic                          valid;
  logic                          ready;
  logic [esps_pkg::ID_W-1:0]     src_vertex;
  logic [esps_pkg::ID_W-1:0]     dst_vertex;

  modport source (output valid, output src_vertex, output dst_vertex, input ready);
  modport sink (input valid, input src_vertex, input dst_vertex, output ready);
endinterface

interface esps_part_if;
  logic       valid;
  logic       ready;
  logic [2:0] chosen_part;
  logic       by_default;

  modport source (output valid, output chosen_part, output by_default, input ready);
  modport sink (input valid, input chosen_part, input by_default, output ready);
endinterface

`default_nettype wire

### sv/esps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module esps_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### sv/esps_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, shared by all
// divisions of the scorer. Depends on esps_pkg.
`default_nettype none

module esps_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [esps_pkg::DIV_W-1:0]   num_i,
  input  wire logic [esps_pkg::DIV_W-1:0]   den_i,
  output      logic [esps_pkg::DIV_W-1:0]   quot_o,
  output      esps_pkg::div_stat_t          stat_o
);

  localparam int unsigned W  = esps_pkg::DIV_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  num_q, den_q;
  logic [W:0]    rem_q;
  logic [W:0]    rem_sh;
  logic          ge;

  assign rem_sh = {rem_q[W-1:0], num_q[W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[W-2:0], ge};
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    end
  end

  assign quot_o      = num_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

### sv/streaming_edge_partition_scorer_core.sv
// Streaming edge partition scorer. After reset a clearing pass writes zero to
// every vertex row, during which no edge is taken. Each edge is scored over
// every partition in use, with a minimum scan after the load update; skipped
// partitions are cheaper than eligible ones, which also divide once a
// spread is known. Ids are reduced first when VERTEX_COUNT is not a power of
// two and below 65536. All divisions share one divider. One edge at a time:
// the next edge is taken in the idle state after the result is registered.
`default_nettype none

module streaming_edge_partition_scorer_core #(
  parameter int unsigned NUM_PARTS    = 8,
  parameter int unsigned VERTEX_COUNT = 65536
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  esps_edge_if.sink                                edge_i,
  esps_part_if.source                              part_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [esps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [esps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW    = $clog2(VERTEX_COUNT);
  localparam int unsigned PW    = $clog2(NUM_PARTS);
  localparam int unsigned CW    = $clog2(NUM_PARTS + 1);
  localparam int unsigned ROW_W = esps_pkg::DEG_W + NUM_PARTS;
  localparam bit IS_POW2  = (VERTEX_COUNT & (VERTEX_COUNT - 1)) == 0;
  localparam bit NEED_MOD = (VERTEX_COUNT < 65536) && !IS_POW2;
  // Rounded-up reciprocal of VERTEX_COUNT scaled by 2^32; exact for 16-bit ids.
  localparam longint unsigned MOD_RECIP =
    ((64'd1 << 32) + 64'(VERTEX_COUNT) - 64'd1) / 64'(VERTEX_COUNT);

  // Configuration registers: user must write only while block is idle; not enforced.
  logic [3:0]  cfg_parts_q;
  logic [31:0] cfg_limit_q;
  logic [15:0] cfg_weight_q;
  logic [31:0] cfg_eps_q;

  esps_pkg::state_e state_q, state_d;

  // Per-edge working registers.
  logic [15:0]          id_u_q, id_v_q;
  logic [15:0]          mod_quot_q;
  logic [AW-1:0]        u_q, v_q;
  logic [31:0]          du_q, dv_q;
  logic [NUM_PARTS-1:0] repu_q, repv_q;
  logic [17:0]          tu_q, tv_q;
  logic [CW-1:0]        j_q;
  logic [PW-1:0]        win_q;
  logic                 found_q;
  logic [esps_pkg::SCORE_W-1:0] best_q;
  logic [esps_pkg::REP_W-1:0]   rep_q;
  logic [esps_pkg::BAL_W-1:0]   bal_q;
  logic [47:0]          plo_q;
  logic [31:0]          phi_q;
  logic [31:0]          min_q;
  logic [AW-1:0]        clr_q;

  // Partition load state.
  logic [31:0] part_load_q [NUM_PARTS];
  logic [31:0] largest_q, smallest_q;
  logic        spread_known_q;

  logic        out_valid_q;
  logic [2:0]  out_part_q;
  logic        out_dflt_q;

  // Vertex row memory: degree above replica bits.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [ROW_W-1:0]     ram_wdata, ram_rdata;

  // Shared divider.
  logic                 div_start;
  logic [63:0]          div_num, div_den, div_quot;
  esps_pkg::div_stat_t  div_stat;

  esps_ram #(
    .WIDTH (ROW_W),
    .DEPTH (VERTEX_COUNT)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  esps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  // Derived values used by several states.
  logic [CW-1:0]        n_act;
  logic [PW-1:0]        ld_idx;
  logic [31:0]          cur_load;
  logic [31:0]          new_load;
  logic [31:0]          rd_deg, deg_inc;
  logic [NUM_PARTS-1:0] rd_rep, win_bit;
  logic [32:0]          deg_sum;
  logic [31:0]          diff, spread, eps_eff;
  logic [48:0]          bal_den;
  logic                 eligible, in_range, scan_last;
  logic [63:0]          prod;
  logic [esps_pkg::SCORE_W-1:0] score;
  logic [31:0]          scan_min;
  logic                 in_xfer, out_free;
  logic [15:0]          mod_id, mod_rem;
  logic [47:0]          mod_prod;
  logic [31:0]          mod_back;

  always_comb begin
    if (cfg_parts_q == 4'd0) begin
      n_act = CW'(1);
    end else if (32'(cfg_parts_q) > NUM_PARTS) begin
      n_act = CW'(NUM_PARTS);
    end else begin
      n_act = CW'(cfg_parts_q);
    end
  end

  // Id reduction: the quotient comes from a reciprocal multiply in ST_MODU or ST_MODV,
  // the remainder from a multiply-back and subtract in ST_MODU_W or ST_MODV_W.
  assign mod_id    = ((state_q == esps_pkg::ST_MODU) || (state_q == esps_pkg::ST_MODU_W))
                   ? id_u_q : id_v_q;
  assign mod_prod  = {32'd0, mod_id} * {16'd0, 32'(MOD_RECIP)};
  assign mod_back  = {16'd0, mod_quot_q} * 32'(VERTEX_COUNT);
  assign mod_rem   = mod_id - mod_back[15:0];

  assign ld_idx    = (state_q == esps_pkg::ST_LOAD) ? win_q : j_q[PW-1:0];
  assign cur_load  = part_load_q[ld_idx];
  assign new_load  = (cur_load == esps_pkg::SAT32) ? cur_load : cur_load + 32'd1;
  assign rd_deg    = ram_rdata[ROW_W-1:NUM_PARTS];
  assign rd_rep    = ram_rdata[NUM_PARTS-1:0];
  assign deg_inc   = (rd_deg == esps_pkg::SAT32) ? rd_deg : rd_deg + 32'd1;
  assign win_bit   = NUM_PARTS'(1) << win_q;
  assign deg_sum   = {1'b0, du_q} + {1'b0, dv_q};
  assign diff      = (largest_q >= cur_load) ? largest_q - cur_load : 32'd0;
  assign spread    = (largest_q >= smallest_q) ? largest_q - smallest_q : 32'd0;
  assign eps_eff   = (cfg_eps_q == 32'd0) ? 32'd1 : cfg_eps_q;
  assign bal_den   = {17'd0, eps_eff} + {1'b0, spread, 16'd0};
  assign in_range  = j_q < n_act;
  assign eligible  = cur_load < cfg_limit_q;
  assign scan_last = (j_q + CW'(1)) == n_act;
  assign prod      = {phi_q, 32'd0} + {16'd0, plo_q};
  assign score     = {1'b0, prod[63:8]} + esps_pkg::SCORE_W'(rep_q);
  assign scan_min  = ((j_q == '0) || (cur_load < min_q)) ? cur_load : min_q;
  assign in_xfer   = edge_i.valid && edge_i.ready;
  assign out_free  = !out_valid_q || part_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      esps_pkg::ST_CLEAR:  if (clr_q == AW'(VERTEX_COUNT - 1)) state_d = esps_pkg::ST_IDLE;
      esps_pkg::ST_IDLE: begin
        if (edge_i.valid) state_d = NEED_MOD ? esps_pkg::ST_MODU : esps_pkg::ST_RDU;
      end
      esps_pkg::ST_MODU:   state_d = esps_pkg::ST_MODU_W;
      esps_pkg::ST_MODU_W: state_d = esps_pkg::ST_MODV;
      esps_pkg::ST_MODV:   state_d = esps_pkg::ST_MODV_W;
      esps_pkg::ST_MODV_W: state_d = esps_pkg::ST_RDU;
      esps_pkg::ST_RDU:    state_d = esps_pkg::ST_UPDU;
      esps_pkg::ST_UPDU:   state_d = esps_pkg::ST_RDV;
      esps_pkg::ST_RDV:    state_d = esps_pkg::ST_UPDV;
      esps_pkg::ST_UPDV:   state_d = esps_pkg::ST_DIVU;
      esps_pkg::ST_DIVU:   state_d = esps_pkg::ST_DIVU_W;
      esps_pkg::ST_DIVU_W: if (div_stat.done) state_d = esps_pkg::ST_DIVV;
      esps_pkg::ST_DIVV:   state_d = esps_pkg::ST_DIVV_W;
      esps_pkg::ST_DIVV_W: if (div_stat.done) state_d = esps_pkg::ST_PCHK;
      esps_pkg::ST_PCHK: begin
        if (!in_range) begin
          state_d = esps_pkg::ST_LOAD;
        end else if (eligible) begin
          state_d = spread_known_q ? esps_pkg::ST_PDIV_W : esps_pkg::ST_MUL_LO;
        end
      end
      esps_pkg::ST_PDIV_W: if (div_stat.done) state_d = esps_pkg::ST_MUL_LO;
      esps_pkg::ST_MUL_LO: state_d = esps_pkg::ST_MUL_HI;
      esps_pkg::ST_MUL_HI: state_d = esps_pkg::ST_CMP;
      esps_pkg::ST_CMP:    state_d = esps_pkg::ST_PCHK;
      esps_pkg::ST_LOAD:   state_d = esps_pkg::ST_WRU;
      esps_pkg::ST_WRU:    state_d = esps_pkg::ST_WRV;
      esps_pkg::ST_WRV:    state_d = esps_pkg::ST_SCAN;
      esps_pkg::ST_SCAN:   if (scan_last) state_d = esps_pkg::ST_DONE;
      esps_pkg::ST_DONE:   if (out_free) state_d = esps_pkg::ST_IDLE;
      default:             state_d = esps_pkg::ST_IDLE;
    endcase
  end

  // Memory and divider controls.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = u_q;
    ram_wdata = {du_q, repu_q | win_bit};
    ram_raddr = u_q;
    div_start = 1'b0;
    div_num   = {16'd0, du_q, 16'd0};
    div_den   = {31'd0, deg_sum};
    case (state_q)
      esps_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      esps_pkg::ST_UPDU: begin
        ram_we    = 1'b1;
        ram_wdata = {deg_inc, rd_rep};
      end
      esps_pkg::ST_RDV:  ram_raddr = v_q;
      esps_pkg::ST_UPDV: begin
        ram_we    = 1'b1;
        ram_waddr = v_q;
        ram_wdata = {deg_inc, rd_rep};
      end
      esps_pkg::ST_DIVU: div_start = 1'b1;
      esps_pkg::ST_DIVV: begin
        div_start = 1'b1;
        div_num   = {16'd0, dv_q, 16'd0};
      end
      esps_pkg::ST_PCHK: begin
        div_start = in_range && eligible && spread_known_q;
        div_num   = {diff, 32'd0};
        div_den   = {15'd0, bal_den};
      end
      esps_pkg::ST_WRU: ram_we = 1'b1;
      esps_pkg::ST_WRV: begin
        ram_we    = 1'b1;
        ram_waddr = v_q;
        ram_wdata = {dv_q, repv_q | win_bit};
      end
      default: ;
    endcase
  end

  assign edge_i.ready     = (state_q == esps_pkg::ST_IDLE);
  assign part_o.valid       = out_valid_q;
  assign part_o.chosen_part = out_part_q;
  assign part_o.by_default  = out_dflt_q;

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= esps_pkg::ST_CLEAR;
      clr_q          <= '0;
      cfg_parts_q    <= 4'd8;
      cfg_limit_q    <= esps_pkg::SAT32;
      cfg_weight_q   <= 16'd256;
      cfg_eps_q      <= 32'd65536;
      for (int i = 0; i < NUM_PARTS; i++) begin
        part_load_q[i] <= '0;
      end
      largest_q      <= '0;
      smallest_q     <= '0;
      spread_known_q <= 1'b0;
      out_valid_q    <= 1'b0;
      j_q            <= '0;
      win_q          <= '0;
      found_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          esps_pkg::CFG_PARTS_IN_USE:    cfg_parts_q  <= cfg_data_i[3:0];
          esps_pkg::CFG_LOAD_LIMIT:      cfg_limit_q  <= cfg_data_i;
          esps_pkg::CFG_BALANCE_WEIGHT:  cfg_weight_q <= cfg_data_i[15:0];
          esps_pkg::CFG_BALANCE_EPSILON: cfg_eps_q    <= cfg_data_i;
          default: ;
        endcase
      end
      // The result register is loaded when it is free or being emptied in
      // the same cycle; otherwise a transfer empties it.
      if ((state_q == esps_pkg::ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (part_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        esps_pkg::ST_CLEAR: clr_q <= clr_q + AW'(1);
        esps_pkg::ST_IDLE: begin
          if (in_xfer) begin
            j_q     <= '0;
            win_q   <= '0;
            found_q <= 1'b0;
          end
        end
        esps_pkg::ST_PCHK: begin
          if (in_range && !eligible) j_q <= j_q + CW'(1);
        end
        esps_pkg::ST_CMP: begin
          if (score > best_q) begin
            win_q   <= j_q[PW-1:0];
            found_q <= 1'b1;
          end
          j_q <= j_q + CW'(1);
        end
        esps_pkg::ST_LOAD: begin
          part_load_q[win_q] <= new_load;
          if (new_load > largest_q) largest_q <= new_load;
          j_q <= '0;
        end
        esps_pkg::ST_SCAN: begin
          j_q <= j_q + CW'(1);
          if (scan_last) begin
            smallest_q     <= scan_min;
            spread_known_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      esps_pkg::ST_IDLE: begin
        id_u_q <= edge_i.src_vertex;
        id_v_q <= edge_i.dst_vertex;
        u_q    <= AW'(edge_i.src_vertex);
        v_q    <= AW'(edge_i.dst_vertex);
        best_q <= '0;
      end
      esps_pkg::ST_MODU:   mod_quot_q <= mod_prod[47:32];
      esps_pkg::ST_MODU_W: u_q <= AW'(mod_rem);
      esps_pkg::ST_MODV:   mod_quot_q <= mod_prod[47:32];
      esps_pkg::ST_MODV_W: v_q <= AW'(mod_rem);
      esps_pkg::ST_UPDU: begin
        du_q   <= deg_inc;
        repu_q <= rd_rep;
      end
      esps_pkg::ST_UPDV: begin
        dv_q   <= deg_inc;
        repv_q <= rd_rep;
      end
      esps_pkg::ST_DIVU_W: if (div_stat.done) tu_q <= 18'h2_0000 - div_quot[17:0];
      esps_pkg::ST_DIVV_W: if (div_stat.done) tv_q <= 18'h2_0000 - div_quot[17:0];
      esps_pkg::ST_PCHK: begin
        rep_q <= (repu_q[j_q[PW-1:0]] ? esps_pkg::REP_W'(tu_q) : '0)
               + (repv_q[j_q[PW-1:0]] ? esps_pkg::REP_W'(tv_q) : '0);
        bal_q <= {diff, 16'd0};
      end
      esps_pkg::ST_PDIV_W: begin
        if (div_stat.done) begin
          bal_q <= (div_quot > esps_pkg::BAL_MAX) ? esps_pkg::BAL_MAX[47:0] : div_quot[47:0];
        end
      end
      esps_pkg::ST_MUL_LO: plo_q <= bal_q[31:0] * cfg_weight_q;
      esps_pkg::ST_MUL_HI: phi_q <= bal_q[47:32] * cfg_weight_q;
      esps_pkg::ST_CMP:    if (score > best_q) best_q <= score;
      esps_pkg::ST_SCAN:   min_q <= scan_min;
      esps_pkg::ST_DONE: begin
        if (out_free) begin
          out_part_q <= 3'(win_q);
          out_dflt_q <= !found_q;
        end
      end
      default: ;
    endcase
  end

  // The divider is only started while it is free.
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A new result only appears out of the final state of an edge.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == esps_pkg::ST_DONE)
    else $error("result raised outside the final state");

  // The smallest in-use load never exceeds the largest load ever seen.
  a_spread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smallest_q <= largest_q)
    else $error("smallest load above largest load");

  // No vertex row is written while an edge transfer is being accepted.
  a_no_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> !ram_we)
    else $error("row write during edge acceptance");

endmodule

`default_nettype wire
